### design/i2cm_pkg.sv
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared types and constants of the I2C master byte engine.
// ----------------------------------------------------------------------------
package i2cm_pkg;

   localparam logic [2:0] OP_IDLE  = 3'd0;
   localparam logic [2:0] OP_START = 3'd1;
   localparam logic [2:0] OP_STOP  = 3'd2;
   localparam logic [2:0] OP_WRITE = 3'd3;
   localparam logic [2:0] OP_READ  = 3'd4;

   localparam logic [7:0] PHASE_TICKS_RESET = 8'd70;

   // phases per command
   localparam logic [4:0] START_PHASES = 5'd4;
   localparam logic [4:0] STOP_PHASES  = 5'd3;
   localparam logic [4:0] WRITE_PHASES = 5'd27;
   localparam logic [4:0] READ_PHASES  = 5'd19;

   // one result beat
   typedef struct packed {
      logic       ack_seen;
      logic [7:0] read_byte;
      logic       done_res;
      logic       busy_res;
      logic       sda_pull;
      logic       scl_pull;
   } result_type;

   function automatic logic [4:0] phase_total(input logic [2:0] op);
      logic [4:0] total;
      begin
         unique case (op)
            OP_START: total = START_PHASES;
            OP_STOP:  total = STOP_PHASES;
            OP_WRITE: total = WRITE_PHASES;
            OP_READ:  total = READ_PHASES;
            default:  total = 5'd0;
         endcase
         return total;
      end
   endfunction

endpackage

### design/i2cm_seq.sv
// ----------------------------------------------------------------------------
// i2cm_seq
// Phase sequencer: bus line state, phase and tick counters, one step per beat.
// ----------------------------------------------------------------------------
module i2cm_seq import i2cm_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic [7:0] csr_wr_data,
   input  logic       step_en,
   input  logic [2:0] command,
   input  logic [7:0] write_byte,
   input  logic       send_ack,
   input  logic       sda_in,
   output result_type result
);

   logic [7:0] phase_ticks_ff;
   logic       scl_pulled_ff, scl_pulled_in;
   logic       sda_pulled_ff, sda_pulled_in;
   logic [2:0] active_op_ff, active_op_in;
   logic [4:0] phase_index_ff, phase_index_in;
   logic [7:0] tick_count_ff, tick_count_in;
   logic [7:0] shift_byte_ff, shift_byte_in;
   logic       ack_flag_ff, ack_flag_in;
   logic       ack_hold_ff, ack_hold_in;
   logic [7:0] last_read_ff, last_read_in;

   logic       apply;
   logic       done;
   logic [7:0] tick_sum;
   logic [4:0] next_phase;
   logic [8:0] div_prod;
   logic [3:0] bit_no;
   logic [4:0] sub_phase;

   always_comb begin
      scl_pulled_in  = scl_pulled_ff;
      sda_pulled_in  = sda_pulled_ff;
      active_op_in   = active_op_ff;
      phase_index_in = phase_index_ff;
      tick_count_in  = tick_count_ff;
      shift_byte_in  = shift_byte_ff;
      ack_flag_in    = ack_flag_ff;
      ack_hold_in    = ack_hold_ff;
      last_read_in   = last_read_ff;
      apply          = 1'b0;
      done           = 1'b0;
      tick_sum       = tick_count_ff + 8'd1;
      next_phase     = phase_index_ff + 5'd1;

      if (active_op_ff == OP_IDLE) begin
         if (command >= OP_START && command <= OP_READ) begin
            active_op_in   = command;
            phase_index_in = 5'd0;
            tick_count_in  = 8'd0;
            if (command == OP_WRITE) shift_byte_in = write_byte;
            if (command == OP_READ) begin
               shift_byte_in = 8'd0;
               ack_hold_in   = send_ack;
            end
            apply = 1'b1;
         end
      end else begin
         tick_count_in = tick_sum;
         // a zero length compares as always reached, i.e. one tick
         if (tick_sum >= phase_ticks_ff) begin
            tick_count_in = 8'd0;
            if (next_phase >= phase_total(active_op_ff)) begin
               if (active_op_ff == OP_READ) last_read_in = shift_byte_ff;
               active_op_in   = OP_IDLE;
               phase_index_in = 5'd0;
               done           = 1'b1;
            end else begin
               phase_index_in = next_phase;
               apply          = 1'b1;
            end
         end
      end

      // phase / 3 as multiply by 11/32, exact for phases below 32
      div_prod  = 9'(phase_index_in) * 9'd11;
      bit_no    = div_prod[8:5];
      sub_phase = phase_index_in - 5'(bit_no) * 5'd3;

      if (apply) begin
         case (active_op_in)
            OP_START: begin
               case (phase_index_in)
                  5'd0:    sda_pulled_in = 1'b0;
                  5'd1:    scl_pulled_in = 1'b0;
                  5'd2:    sda_pulled_in = 1'b1;
                  default: scl_pulled_in = 1'b1;
               endcase
            end
            OP_STOP: begin
               case (phase_index_in)
                  5'd0:    sda_pulled_in = 1'b1;
                  5'd1:    scl_pulled_in = 1'b0;
                  default: sda_pulled_in = 1'b0;
               endcase
            end
            OP_WRITE: begin
               if (phase_index_in < 5'd24) begin
                  case (sub_phase)
                     5'd0:    sda_pulled_in = ~shift_byte_in[3'd7 - bit_no[2:0]];
                     5'd1:    scl_pulled_in = 1'b0;
                     default: scl_pulled_in = 1'b1;
                  endcase
               end else if (phase_index_in == 5'd24) begin
                  sda_pulled_in = 1'b0;
               end else if (phase_index_in == 5'd25) begin
                  scl_pulled_in = 1'b0;
                  ack_flag_in   = ~sda_in;
               end else begin
                  scl_pulled_in = 1'b1;
               end
            end
            OP_READ: begin
               if (phase_index_in < 5'd16) begin
                  if (!phase_index_in[0]) begin
                     scl_pulled_in = 1'b0;
                     shift_byte_in = {shift_byte_in[6:0], sda_in};
                  end else begin
                     scl_pulled_in = 1'b1;
                  end
               end else if (phase_index_in == 5'd16) begin
                  sda_pulled_in = ack_hold_in;
               end else if (phase_index_in == 5'd17) begin
                  scl_pulled_in = 1'b0;
               end else begin
                  scl_pulled_in = 1'b1;
                  sda_pulled_in = 1'b0;
               end
            end
            default: ;
         endcase
      end

      result.scl_pull  = scl_pulled_in;
      result.sda_pull  = sda_pulled_in;
      result.busy_res  = (active_op_in != OP_IDLE);
      result.done_res  = done;
      result.read_byte = last_read_in;
      result.ack_seen  = ack_flag_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ticks_ff <= PHASE_TICKS_RESET;
         scl_pulled_ff  <= 1'b0;
         sda_pulled_ff  <= 1'b0;
         active_op_ff   <= OP_IDLE;
         phase_index_ff <= 5'd0;
         tick_count_ff  <= 8'd0;
         shift_byte_ff  <= 8'd0;
         ack_flag_ff    <= 1'b0;
         ack_hold_ff    <= 1'b0;
         last_read_ff   <= 8'd0;
      end else begin
         if (csr_wr_en) phase_ticks_ff <= csr_wr_data;
         if (step_en) begin
            scl_pulled_ff  <= scl_pulled_in;
            sda_pulled_ff  <= sda_pulled_in;
            active_op_ff   <= active_op_in;
            phase_index_ff <= phase_index_in;
            tick_count_ff  <= tick_count_in;
            shift_byte_ff  <= shift_byte_in;
            ack_flag_ff    <= ack_flag_in;
            ack_hold_ff    <= ack_hold_in;
            last_read_ff   <= last_read_in;
         end
      end
   end

endmodule

### design/i2cm_outq.sv
// ----------------------------------------------------------------------------
// i2cm_outq
// Two-entry result queue: circular buffer with read and write pointers.
// ----------------------------------------------------------------------------
module i2cm_outq import i2cm_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  result_type push_data,
   output logic       full,
   output logic       out_valid,
   input  logic       out_ready,
   output result_type out_data
);

   result_type entry_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff, count_in;
   logic       pop;

   assign pop       = out_valid && out_ready;
   assign full      = (count_ff == 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_data  = entry_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) count_in = count_ff + 2'd1;
      else if (!push && pop) count_in = count_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop) rd_ptr_ff <= ~rd_ptr_ff;
         count_ff <= count_in;
      end
   end

endmodule

### design/i2c_master_byte_engine.sv
// The result of a tick beat is registered in the queue and shown on rsp once older beats are taken.
// Throughput: one tick beat per cycle while rsp is drained; the sequencer
// state is updated as each beat is taken and a two-entry queue buffers results.
// req_tready drops only when both queue entries hold untaken beats.
// Reset (synchronous, active high): lines released, idle, phase_ticks = 70,
// queue empty.
// ----------------------------------------------------------------------------
// i2c_master_byte_engine
// Open-drain I2C master stepping SCL/SDA phases one tick beat at a time.
// ----------------------------------------------------------------------------
module i2c_master_byte_engine import i2cm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data,   // phase_ticks
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,     // write_byte[7:0], send_ack[8], sda_in[9], zero
   input  logic [2:0]  req_tuser,     // command[2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata      // scl_pull[0], sda_pull[1], busy_res[2],
                                      // done_res[3], read_byte[11:4], ack_seen[12]
);

   logic       step_en;
   logic       q_full;
   result_type step_res;
   result_type out_res;

   assign req_tready = ~q_full;
   assign step_en    = req_tvalid && req_tready;

   i2cm_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .step_en     (step_en),
      .command     (req_tuser),
      .write_byte  (req_tdata[7:0]),
      .send_ack    (req_tdata[8]),
      .sda_in      (req_tdata[9]),
      .result      (step_res)
   );

   i2cm_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .push      (step_en),
      .push_data (step_res),
      .full      (q_full),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (out_res)
   );

   assign rsp_tdata = {3'd0, out_res.ack_seen, out_res.read_byte, out_res.done_res,
                       out_res.busy_res, out_res.sda_pull, out_res.scl_pull};

endmodule

### design/i2cm_checker.sv
// ----------------------------------------------------------------------------
// i2cm_checker
// Port-level checks of the I2C master byte engine, bound to the top level.
// ----------------------------------------------------------------------------
module i2cm_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata
);

   // stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp beat changed while stalled");

   // the done tick is the one that goes idle
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[3] |-> !rsp_tdata[2])
      else $error("done raised while busy");

   // back pressure only comes from a stalled output
   a_ready_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("req stalled with empty output");

   // an accepted beat always leaves a result beat valid next cycle
   a_beat_out: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> rsp_tvalid)
      else $error("accepted beat produced no result");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind i2c_master_byte_engine i2cm_checker u_i2cm_checker (.*);
